/* hw/rtl/nfrc_pkg.sv */
// ============================================================================
// nfrc_pkg: shared types and helpers for the Newton fractal root classifier
// Fixed-point complex type, saturating arithmetic, item and divider structs.
// ============================================================================
`default_nettype none

package nfrc_pkg;

    localparam int MATCH_ROOTS = 5;
    localparam logic [2:0] NO_ROOT = 3'd5;

    localparam logic [2:0] CFG_TOLERANCE = 3'd5;
    localparam logic [2:0] CFG_LIMIT     = 3'd6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_DERIV = 2'd1;
    localparam logic [1:0] ST_LIMIT      = 2'd2;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } cq_t;

    typedef struct packed {
        logic signed [31:0] start_re;
        logic signed [31:0] start_im;
    } start_item_t;

    typedef struct packed {
        logic signed [31:0] final_re;
        logic signed [31:0] final_im;
        logic [2:0]         root_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [15:0]        steps_taken;
        logic [1:0]         status;
    } result_item_t;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] quot;
    } div_rsp_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat33({a[31], a} - {b[31], b});
    endfunction

    function automatic cq_t csub(input cq_t a, input cq_t b);
        cq_t r;
        r.re = sub_sat(a.re, b.re);
        r.im = sub_sat(a.im, b.im);
        return r;
    endfunction

    function automatic cq_t cadd(input cq_t a, input cq_t b);
        cq_t r;
        r.re = add_sat(a.re, b.re);
        r.im = add_sat(a.im, b.im);
        return r;
    endfunction

    // Colour as {red, green, blue} for a matched root.
    function automatic logic [23:0] root_colour(input logic [2:0] idx);
        logic [23:0] c;
        unique case (idx)
            3'd1:    c = {8'd55, 8'd10, 8'd17};
            3'd2:    c = {8'd123, 8'd21, 8'd36};
            3'd3:    c = {8'd81, 8'd13, 8'd24};
            3'd4:    c = {8'd165, 8'd28, 8'd48};
            default: c = 24'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/nfrc_mul.sv */
// ============================================================================
// nfrc_mul: shared registered multiplier
// One signed 32 x 32 product per cycle, exact 64-bit result in a register.
// ============================================================================
`default_nettype none

module nfrc_mul
    import nfrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [31:0] op_a,
    input  wire logic signed [31:0] op_b,
    output logic signed [63:0]      prod
);

    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* hw/rtl/nfrc_div.sv */
// ============================================================================
// nfrc_div: iterative fixed-point divider
// Restoring division of mag * 2^FRAC_BITS by den, one bit per cycle, with
// truncation toward zero and saturation of the signed 32-bit quotient.
// ============================================================================
`default_nettype none

module nfrc_div
    import nfrc_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_req_t req,
    output div_rsp_t rsp
);

    localparam int NW = 64 + FRAC_BITS;
    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0]      num_reg;
    logic [64:0]        rem_reg;
    logic [63:0]        den_reg;
    logic [31:0]        q_reg;
    logic               ovf_reg;
    logic               neg_reg;
    logic [KW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [31:0] quot_reg;

    logic [64:0] shifted;
    logic        fits;
    logic [64:0] rem_next;
    logic [31:0] q_next;
    logic        ovf_next;

    always_comb
    begin
        shifted  = {rem_reg[63:0], num_reg[NW-1]};
        fits     = (shifted >= {1'b0, den_reg});
        rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;
        q_next   = {q_reg[30:0], fits};
        ovf_next = ovf_reg | q_reg[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    num_reg  <= {req.mag, FRAC_BITS'(0)};
                    rem_reg  <= '0;
                    den_reg  <= req.den;
                    q_reg    <= '0;
                    ovf_reg  <= 1'b0;
                    neg_reg  <= req.neg;
                    cnt_reg  <= KW'(NW);
                    busy_reg <= 1'b1;
                end
            end
            else
            begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                rem_reg <= rem_next;
                q_reg   <= q_next;
                ovf_reg <= ovf_next;
                cnt_reg <= cnt_reg - KW'(1);
                if (cnt_reg == KW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    // A quotient of 2^31 or more saturates toward the sign.
                    if (ovf_next || q_next[31])
                    begin
                        quot_reg <= neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                    end
                    else
                    begin
                        quot_reg <= neg_reg ? -$signed(q_next) : $signed(q_next);
                    end
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

/* hw/rtl/newton_fractal_root_classifier_top.sv */
// ============================================================================
// Newton fractal root classifier
// Runs Newton iteration from one complex start point on a polynomial given by
// its roots and reports the final point, the matched root and its colour.
//
// Usage: a start item (start_re, start_im, signed fixed point) is taken on the
// start channel when start_valid is high and start_stall is low. start_stall
// stays high while a point is being worked on. One result item per start item
// appears on the result channel and is held in an output register until
// result_stall is low, while the next start item may already be taken.
// The roots, tolerance and iteration limit are written through cfg_write,
// cfg_index and cfg_data; the user must do so only while the block is idle,
// which the block itself does not enforce. Each Newton step is paced by the
// single shared multiplier, which forms the complex products one real product
// at a time, and by the bit-serial divider, which forms the real and imaginary
// quotient parts one after the other. Each item also passes through setup,
// root matching and output. A new start item is taken only once the previous
// result has gone to the output register.
// Reset restores the configuration defaults and empties the output register.
// ============================================================================
`default_nettype none

module newton_fractal_root_classifier_top
    import nfrc_pkg::*;
#(
    parameter int NUM_ROOTS = 5,
    parameter int FRAC_BITS = 24
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start_valid,
    output logic              start_stall,
    input  wire start_item_t  start_item,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_item_t      result_item,
    input  wire logic         cfg_write,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);

    localparam int IW = (NUM_ROOTS > 1) ? $clog2(NUM_ROOTS) : 1;
    localparam int CW = $clog2(NUM_ROOTS + 2);
    localparam int MR = (NUM_ROOTS < MATCH_ROOTS) ? NUM_ROOTS : MATCH_ROOTS;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam cq_t CQ_ONE = '{re: ONE, im: 32'sd0};

    typedef enum logic [3:0] {
        S_IDLE, S_EPS, S_EPSW, S_DIFF, S_CMUL, S_CHK,
        S_PROD, S_DIVR, S_DIVI, S_MATCH, S_DONE
    } state_t;

    function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
        return sat64(p >>> FRAC_BITS);
    endfunction

    state_t             state_reg;
    cq_t                roots_reg [NUM_ROOTS];
    cq_t                diff_reg [NUM_ROOTS];
    logic [30:0]        tol_reg;
    logic [15:0]        lim_reg;
    cq_t                x_reg;
    cq_t                acc_reg;
    cq_t                f_reg;
    cq_t                d_reg;
    logic signed [31:0] m0_reg;
    logic signed [31:0] m1_reg;
    logic signed [31:0] m2_reg;
    logic [63:0]        magf_reg;
    logic [63:0]        den_reg;
    logic signed [64:0] s1_reg;
    logic signed [64:0] s2_reg;
    logic [63:0]        eps2_reg;
    logic [63:0]        mm_reg;
    logic signed [31:0] qre_reg;
    logic [15:0]        iter_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [3:0]         ph_reg;
    logic               fmode_reg;
    logic [1:0]         status_reg;
    logic [2:0]         idx_reg;
    logic               out_valid_reg;
    result_item_t       out_item_reg;

    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] prod;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [15:0]        lim_eff;
    cq_t                root_sel;
    cq_t                mdiff;
    cq_t                b_op;
    cq_t                acc_new;
    cq_t                d_sum;
    cq_t                x_upd;
    logic [CW-1:0]      j_inc;
    logic [CW-1:0]      j_skip;
    logic [15:0]        iter_inc;
    logic [63:0]        match_sum;
    logic [64:0]        s1_abs;
    logic [64:0]        s2_abs;
    logic               start_accept;

    nfrc_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    nfrc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign start_stall  = (state_reg != S_IDLE);
    assign start_accept = start_valid && !start_stall;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_comb
    begin
        lim_eff   = (lim_reg == 16'd0) ? 16'd1 : lim_reg;
        root_sel  = roots_reg[k_reg[IW-1:0]];
        mdiff     = csub(x_reg, root_sel);
        b_op      = diff_reg[j_reg[IW-1:0]];
        acc_new.re = sub_sat(m0_reg, m1_reg);
        acc_new.im = add_sat(m2_reg, mulq(prod));
        d_sum     = cadd(d_reg, acc_new);
        x_upd     = csub(x_reg, '{re: qre_reg, im: div_rsp.quot});
        j_inc     = j_reg + CW'(1);
        j_skip    = (j_inc == i_reg) ? (j_reg + CW'(2)) : j_inc;
        iter_inc  = iter_reg + 16'd1;
        match_sum = mm_reg + $unsigned(prod);
        s1_abs    = s1_reg[64] ? $unsigned(-s1_reg) : $unsigned(s1_reg);
        s2_abs    = s2_reg[64] ? $unsigned(-s2_reg) : $unsigned(s2_reg);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_EPS:
            begin
                op_a = $signed({1'b0, tol_reg});
                op_b = $signed({1'b0, tol_reg});
            end
            S_CMUL:
            begin
                case (ph_reg)
                    4'd0:    begin op_a = acc_reg.re; op_b = b_op.re; end
                    4'd1:    begin op_a = acc_reg.im; op_b = b_op.im; end
                    4'd2:    begin op_a = acc_reg.re; op_b = b_op.im; end
                    4'd3:    begin op_a = acc_reg.im; op_b = b_op.re; end
                    default: begin op_a = '0; op_b = '0; end
                endcase
            end
            S_PROD:
            begin
                case (ph_reg)
                    4'd0:    begin op_a = f_reg.re; op_b = f_reg.re; end
                    4'd1:    begin op_a = f_reg.im; op_b = f_reg.im; end
                    4'd2:    begin op_a = d_reg.re; op_b = d_reg.re; end
                    4'd3:    begin op_a = d_reg.im; op_b = d_reg.im; end
                    4'd4:    begin op_a = f_reg.re; op_b = d_reg.re; end
                    4'd5:    begin op_a = f_reg.im; op_b = d_reg.im; end
                    4'd6:    begin op_a = f_reg.im; op_b = d_reg.re; end
                    4'd7:    begin op_a = f_reg.re; op_b = d_reg.im; end
                    default: begin op_a = '0; op_b = '0; end
                endcase
            end
            S_MATCH:
            begin
                if (ph_reg == 4'd0)
                begin
                    op_a = mdiff.re;
                    op_b = mdiff.re;
                end
                else
                begin
                    op_a = mdiff.im;
                    op_b = mdiff.im;
                end
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // The real part of f/f' starts when the last product is in, the
    // imaginary part as soon as the real part is done.
    always_comb
    begin
        div_req.start = ((state_reg == S_PROD) && (ph_reg == 4'd8))
                     || ((state_reg == S_DIVR) && div_rsp.done);
        div_req.den   = den_reg;
        if (state_reg == S_PROD)
        begin
            div_req.neg = s1_reg[64];
            div_req.mag = s1_abs[63:0];
        end
        else
        begin
            div_req.neg = s2_reg[64];
            div_req.mag = s2_abs[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROOTS; r++)
            begin
                roots_reg[r] <= '0;
            end
            tol_reg <= 31'd17;
            lim_reg <= 16'd1000;
        end
        else if (cfg_write)
        begin
            for (int r = 0; r < NUM_ROOTS; r++)
            begin
                if ((r < MR) && (cfg_index == 3'(r)))
                begin
                    roots_reg[r] <= cfg_data;
                end
            end
            if (cfg_index == CFG_TOLERANCE)
            begin
                tol_reg <= cfg_data[30:0];
            end
            if (cfg_index == CFG_LIMIT)
            begin
                lim_reg <= cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int r = 0; r < NUM_ROOTS; r++)
            begin
                diff_reg[r] <= '0;
            end
            x_reg         <= '0;
            acc_reg       <= '0;
            f_reg         <= '0;
            d_reg         <= '0;
            m0_reg        <= '0;
            m1_reg        <= '0;
            m2_reg        <= '0;
            magf_reg      <= '0;
            den_reg       <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            eps2_reg      <= '0;
            mm_reg        <= '0;
            qre_reg       <= '0;
            iter_reg      <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            ph_reg        <= '0;
            fmode_reg     <= 1'b0;
            status_reg    <= ST_OK;
            idx_reg       <= NO_ROOT;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            // In S_DONE the output register is reloaded below instead.
            if (out_valid_reg && !result_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start_accept)
                    begin
                        x_reg.re   <= start_item.start_re;
                        x_reg.im   <= start_item.start_im;
                        iter_reg   <= '0;
                        status_reg <= ST_OK;
                        idx_reg    <= NO_ROOT;
                        state_reg  <= S_EPS;
                    end
                end
                S_EPS:
                begin
                    state_reg <= S_EPSW;
                end
                S_EPSW:
                begin
                    eps2_reg  <= $unsigned(prod);
                    k_reg     <= '0;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    diff_reg[k_reg[IW-1:0]] <= mdiff;
                    if (k_reg == CW'(NUM_ROOTS - 1))
                    begin
                        acc_reg   <= CQ_ONE;
                        d_reg     <= '0;
                        j_reg     <= '0;
                        fmode_reg <= 1'b1;
                        ph_reg    <= '0;
                        state_reg <= S_CMUL;
                    end
                    else
                    begin
                        k_reg <= k_reg + CW'(1);
                    end
                end
                S_CMUL:
                begin
                    case (ph_reg)
                        4'd1: m0_reg <= mulq(prod);
                        4'd2: m1_reg <= mulq(prod);
                        4'd3: m2_reg <= mulq(prod);
                        default: ;
                    endcase
                    if (ph_reg != 4'd4)
                    begin
                        ph_reg <= ph_reg + 4'd1;
                    end
                    else
                    begin
                        ph_reg <= '0;
                        if (fmode_reg)
                        begin
                            if (j_reg == CW'(NUM_ROOTS - 1))
                            begin
                                // f is complete; the derivative terms follow.
                                f_reg     <= acc_new;
                                acc_reg   <= CQ_ONE;
                                i_reg     <= '0;
                                j_reg     <= CW'(1);
                                fmode_reg <= 1'b0;
                            end
                            else
                            begin
                                acc_reg <= acc_new;
                                j_reg   <= j_inc;
                            end
                        end
                        else if (j_skip >= CW'(NUM_ROOTS))
                        begin
                            d_reg <= d_sum;
                            if (i_reg == CW'(NUM_ROOTS - 1))
                            begin
                                state_reg <= S_CHK;
                            end
                            else
                            begin
                                i_reg   <= i_reg + CW'(1);
                                j_reg   <= '0;
                                acc_reg <= CQ_ONE;
                            end
                        end
                        else
                        begin
                            acc_reg <= acc_new;
                            j_reg   <= j_skip;
                        end
                    end
                end
                S_CHK:
                begin
                    ph_reg <= '0;
                    if ((d_reg.re == 32'sd0) && (d_reg.im == 32'sd0))
                    begin
                        x_reg      <= '0;
                        status_reg <= ST_ZERO_DERIV;
                        k_reg      <= '0;
                        state_reg  <= S_MATCH;
                    end
                    else
                    begin
                        state_reg <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    case (ph_reg)
                        4'd1: magf_reg <= $unsigned(prod);
                        4'd2: magf_reg <= magf_reg + $unsigned(prod);
                        4'd3: den_reg  <= $unsigned(prod);
                        4'd4: den_reg  <= den_reg + $unsigned(prod);
                        4'd5: s1_reg   <= {prod[63], prod};
                        4'd6: s1_reg   <= s1_reg + {prod[63], prod};
                        4'd7: s2_reg   <= {prod[63], prod};
                        4'd8: s2_reg   <= s2_reg - {prod[63], prod};
                        default: ;
                    endcase
                    if (ph_reg == 4'd8)
                    begin
                        state_reg <= S_DIVR;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 4'd1;
                    end
                end
                S_DIVR:
                begin
                    if (div_rsp.done)
                    begin
                        qre_reg   <= div_rsp.quot;
                        state_reg <= S_DIVI;
                    end
                end
                S_DIVI:
                begin
                    if (div_rsp.done)
                    begin
                        x_reg    <= x_upd;
                        iter_reg <= iter_inc;
                        k_reg    <= '0;
                        ph_reg   <= '0;
                        // f here is the value before this step's update.
                        if ((magf_reg > eps2_reg) && (iter_inc < lim_eff))
                        begin
                            state_reg <= S_DIFF;
                        end
                        else if (iter_inc == lim_eff)
                        begin
                            status_reg <= ST_LIMIT;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_MATCH;
                        end
                    end
                end
                S_MATCH:
                begin
                    if (ph_reg == 4'd1)
                    begin
                        mm_reg <= $unsigned(prod);
                    end
                    if (ph_reg != 4'd2)
                    begin
                        ph_reg <= ph_reg + 4'd1;
                    end
                    else
                    begin
                        ph_reg <= '0;
                        // Later roots override earlier matches.
                        if (match_sum < eps2_reg)
                        begin
                            idx_reg <= 3'(k_reg);
                        end
                        if (k_reg == CW'(MR - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            k_reg <= k_reg + CW'(1);
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !result_stall)
                    begin
                        out_item_reg.final_re    <= x_reg.re;
                        out_item_reg.final_im    <= x_reg.im;
                        out_item_reg.root_index  <= idx_reg;
                        {out_item_reg.red, out_item_reg.green, out_item_reg.blue}
                            <= root_colour(idx_reg);
                        out_item_reg.steps_taken <= iter_reg;
                        out_item_reg.status      <= status_reg;
                        out_valid_reg            <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_limit_no_root: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_item.status == ST_LIMIT))
        |-> (result_item.root_index == NO_ROOT))
        else $error("limit result carries a matched root");

    a_zero_deriv_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_item.status == ST_ZERO_DERIV))
        |-> ((result_item.final_re == 32'sd0) && (result_item.final_im == 32'sd0)))
        else $error("zero derivative result is not at the origin");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_iter_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (iter_reg <= lim_eff))
        else $error("step count passed the iteration limit");

endmodule

`default_nettype wire

/* tb/tb_newton_fractal_root_classifier_top.sv */
// ============================================================================
// Testbench for the Newton fractal root classifier
// Start items go in under random idling and a long receiver hold-off, across
// several root, tolerance and limit settings. Every result item is checked field
// by field against a fixed-point Newton predictor, the reset one against a typed item.
// ============================================================================
`default_nettype none

module tb_newton_fractal_root_classifier_top;
    import nfrc_pkg::*;

    localparam int NROOTS      = 5;
    localparam int FB          = 24;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 60;
    localparam int QUIET_ITEMS = 80;
    localparam int HOLD_CYCLES = 3000;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam logic [2:0] CFG_BAD_INDEX = 3'd7;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         start_valid = 1'b0;
    logic         start_stall;
    start_item_t  start_item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;
    logic         cfg_write = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    // Bench copy of the configuration.
    cq_t         root_val[NROOTS];
    logic [30:0] tol_val;
    logic [15:0] lim_val;

    result_item_t pending_results[$];
    int  fail_count;
    int  points_sent;
    int  points_checked;
    int  status_seen[3];
    bit  quiet;
    bit  hold_done;

    newton_fractal_root_classifier_top #(.NUM_ROOTS(NROOTS), .FRAC_BITS(FB)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_valid  (start_valid),
        .start_stall  (start_stall),
        .start_item   (start_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point Newton predictor
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp32(p >>> FB);
    endfunction

    function automatic cq_t cx_mul(input cq_t a, input cq_t b);
        cq_t r;
        r.re = clamp32(longint'(fx_mul(a.re, b.re)) - longint'(fx_mul(a.im, b.im)));
        r.im = clamp32(longint'(fx_mul(a.re, b.im)) + longint'(fx_mul(a.im, b.re)));
        return r;
    endfunction

    function automatic cq_t cx_diff(input cq_t a, input cq_t b);
        cq_t r;
        r.re = clamp32(longint'(a.re) - longint'(b.re));
        r.im = clamp32(longint'(a.im) - longint'(b.im));
        return r;
    endfunction

    function automatic cq_t cx_sum(input cq_t a, input cq_t b);
        cq_t r;
        r.re = clamp32(longint'(a.re) + longint'(b.re));
        r.im = clamp32(longint'(a.im) + longint'(b.im));
        return r;
    endfunction

    function automatic logic [63:0] sq_mag(input cq_t a);
        logic [63:0] x2;
        logic [63:0] y2;
        x2 = longint'(a.re) * longint'(a.re);
        y2 = longint'(a.im) * longint'(a.im);
        return x2 + y2;
    endfunction

    // Exact p1 + p2 as a sign and a magnitude.
    function automatic logic [63:0] signed_sum(input longint p1, input longint p2,
                                               output bit neg);
        logic [63:0] m1;
        logic [63:0] m2;
        m1 = (p1 < 0) ? 64'd0 - 64'(p1) : 64'(p1);
        m2 = (p2 < 0) ? 64'd0 - 64'(p2) : 64'(p2);
        if ((p1 < 0) == (p2 < 0))
        begin
            neg = (p1 < 0);
            return m1 + m2;
        end
        if (m1 >= m2)
        begin
            neg = (p1 < 0);
            return m1 - m2;
        end
        neg = (p2 < 0);
        return m2 - m1;
    endfunction

    function automatic logic signed [31:0] quot_part(input bit neg, input logic [63:0] mag,
                                                     input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        logic signed [31:0] v;
        q = mag / den;
        r = mag % den;
        if (q >= (64'd1 << (31 - FB)))
        begin
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        q = q << FB;
        for (int b = FB - 1; b >= 0; b--)
        begin
            r = r << 1;
            if (r >= den)
            begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        v = q[31:0];
        return neg ? -v : v;
    endfunction

    function automatic cq_t newton_quot(input cq_t f, input cq_t d);
        cq_t r;
        bit neg;
        logic [63:0] den;
        logic [63:0] m;
        den = sq_mag(d);
        m = signed_sum(longint'(f.re) * d.re, longint'(f.im) * d.im, neg);
        r.re = quot_part(neg, m, den);
        m = signed_sum(longint'(f.im) * d.re, -(longint'(f.re) * d.im), neg);
        r.im = quot_part(neg, m, den);
        return r;
    endfunction

    function automatic result_item_t classify_point(input start_item_t s);
        result_item_t res;
        cq_t x;
        cq_t f;
        cq_t d;
        cq_t term;
        cq_t diff[NROOTS];
        logic [63:0] eps2;
        int unsigned steps;
        int unsigned limit;
        logic [1:0] st;
        logic [2:0] idx;
        eps2 = longint'(tol_val) * longint'(tol_val);
        limit = (lim_val == 0) ? 1 : lim_val;
        steps = 0;
        st = ST_OK;
        idx = NO_ROOT;
        x.re = s.start_re;
        x.im = s.start_im;
        forever
        begin
            f.re = 32'sd1 <<< FB;
            f.im = '0;
            d = '0;
            for (int i = 0; i < NROOTS; i++)
            begin
                diff[i] = cx_diff(x, root_val[i]);
                f = cx_mul(f, diff[i]);
            end
            for (int i = 0; i < NROOTS; i++)
            begin
                term.re = 32'sd1 <<< FB;
                term.im = '0;
                for (int j = 0; j < NROOTS; j++)
                begin
                    if (j != i)
                    begin
                        term = cx_mul(term, diff[j]);
                    end
                end
                d = cx_sum(d, term);
            end
            if (d.re == 0 && d.im == 0)
            begin
                x = '0;
                st = ST_ZERO_DERIV;
                break;
            end
            x = cx_diff(x, newton_quot(f, d));
            steps++;
            if (!(sq_mag(f) > eps2 && steps < limit))
            begin
                break;
            end
        end
        if (st == ST_OK && steps == limit)
        begin
            st = ST_LIMIT;
        end
        if (st != ST_LIMIT)
        begin
            for (int i = 0; i < MATCH_ROOTS && i < NROOTS; i++)
            begin
                if (sq_mag(cx_diff(x, root_val[i])) < eps2)
                begin
                    idx = 3'(i);
                end
            end
        end
        res.final_re = x.re;
        res.final_im = x.im;
        res.root_index = idx;
        {res.red, res.green, res.blue} = '0;
        case (idx)
            3'd1: {res.red, res.green, res.blue} = {8'd55, 8'd10, 8'd17};
            3'd2: {res.red, res.green, res.blue} = {8'd123, 8'd21, 8'd36};
            3'd3: {res.red, res.green, res.blue} = {8'd81, 8'd13, 8'd24};
            3'd4: {res.red, res.green, res.blue} = {8'd165, 8'd28, 8'd48};
            default: ;
        endcase
        res.steps_taken = steps[15:0];
        res.status = st;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (index < NROOTS)
        begin
            root_val[index].re = value[63:32];
            root_val[index].im = value[31:0];
        end
        else if (index == CFG_TOLERANCE)
        begin
            tol_val = value[30:0];
        end
        else if (index == CFG_LIMIT)
        begin
            lim_val = value[15:0];
        end
    endtask

    // Leaves valid high after acceptance; the caller lowers it when done.
    task automatic send_point(input start_item_t s, input bit typed,
                              input result_item_t typed_res);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        start_valid <= 1'b1;
        start_item  <= s;
        do
        begin
            @(posedge clk);
        end
        while (start_stall);
        pending_results.push_back(typed ? typed_res : classify_point(s));
        points_sent++;
    endtask

    task automatic drain;
        start_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [31:0] near_value();
        return 32'(int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    endfunction

    function automatic logic signed [31:0] any_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'($urandom);
            default: return near_value();
        endcase
    endfunction

    function automatic logic signed [31:0] to_fix(input real v);
        return 32'($rtoi(v * 16777216.0));
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic check_result(input result_item_t got);
        result_item_t want;
        if (pending_results.size() == 0)
        begin
            $error("result item with nothing expected: %p", got);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        points_checked++;
        if (got.status < 3)
        begin
            status_seen[got.status]++;
        end
        if (got.final_re !== want.final_re)
        begin
            $error("final_re: expected %0d, got %0d", want.final_re, got.final_re);
            fail_count++;
        end
        if (got.final_im !== want.final_im)
        begin
            $error("final_im: expected %0d, got %0d", want.final_im, got.final_im);
            fail_count++;
        end
        if (got.root_index !== want.root_index)
        begin
            $error("root_index: expected %0d, got %0d", want.root_index, got.root_index);
            fail_count++;
        end
        if (got.red !== want.red)
        begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            fail_count++;
        end
        if (got.green !== want.green)
        begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            fail_count++;
        end
        if (got.blue !== want.blue)
        begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            fail_count++;
        end
        if (got.steps_taken !== want.steps_taken)
        begin
            $error("steps_taken: expected %0d, got %0d", want.steps_taken, got.steps_taken);
            fail_count++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
    endtask

    // Receiver: checks accepted result items and drives stall in bursts.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                check_result(result_item);
            end
            if (!hold_done && points_sent >= 120)
            begin
                // Long hold-off so the output register and the input side fill up.
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 15);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        longint cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    typedef struct {
        start_item_t  pt;
        bit           typed;
        result_item_t res;
    } point_row_t;

    initial
    begin
        point_row_t   rows[$];
        point_row_t   row;
        start_item_t  s;
        logic [63:0]  rv;
        fail_count = 0;
        points_sent = 0;
        points_checked = 0;
        status_seen = '{0, 0, 0};
        quiet = 1'b0;
        hold_done = 1'b0;
        foreach (root_val[i])
        begin
            root_val[i] = '0;
        end
        tol_val = 31'd17;
        lim_val = 16'd1000;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // After reset all roots sit at zero, so the origin has a zero derivative
        // and matches every root; the last one, root 4, wins.
        row.pt = '0;
        row.typed = 1'b1;
        row.res = '{final_re: 0, final_im: 0, root_index: 3'd4, red: 8'd165,
                    green: 8'd28, blue: 8'd48, steps_taken: 16'd0, status: ST_ZERO_DERIV};
        send_point(row.pt, row.typed, row.res);
        drain();

        write_reg(3'd0, {to_fix(0.531715), to_fix(1.17575)});
        write_reg(3'd1, {to_fix(-1.21218), to_fix(0.543857)});
        write_reg(3'd2, {to_fix(1.36093), 32'sd0});
        write_reg(3'd3, {to_fix(-1.0), to_fix(-1.0)});
        write_reg(3'd4, {to_fix(0.5), to_fix(-0.75)});
        write_reg(CFG_TOLERANCE, 64'd17);
        write_reg(CFG_LIMIT, 64'd8);
        write_reg(CFG_BAD_INDEX, 64'hdead_beef_0123_4567);

        rows.delete();
        row.typed = 1'b0;
        row.res = '0;
        row.pt = '{32'sd0, 32'sd0};                        rows.push_back(row);
        row.pt = '{32'sh7fff_ffff, 32'sh7fff_ffff};        rows.push_back(row);
        row.pt = '{32'sh8000_0000, 32'sh8000_0000};        rows.push_back(row);
        row.pt = '{32'sh7fff_ffff, 32'sh8000_0000};        rows.push_back(row);
        row.pt = '{32'sh8000_0000, 32'sh7fff_ffff};        rows.push_back(row);
        row.pt = '{32'sh0000_0001, 32'sh0000_0000};        rows.push_back(row);
        row.pt = '{32'shffff_ffff, 32'shffff_ffff};        rows.push_back(row);
        for (int k = 0; k < NROOTS; k++)
        begin
            // Exactly on a root, then just off it.
            row.pt = '{root_val[k].re, root_val[k].im};    rows.push_back(row);
            row.pt = '{root_val[k].re + 32'sd4000, root_val[k].im - 32'sd3000};
            rows.push_back(row);
        end
        row.pt = '{to_fix(-1.0), 32'sd0};                  rows.push_back(row);
        row.pt = '{to_fix(3.0), to_fix(3.0)};              rows.push_back(row);
        foreach (rows[i])
        begin
            send_point(rows[i].pt, rows[i].typed, rows[i].res);
        end
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            for (int k = 0; k < NROOTS; k++)
            begin
                if (p == 6)
                begin
                    rv = {any_value(), any_value()};
                end
                else if (p % 3 == 0 && k < 3)
                begin
                    rv = {root_val[k].re, root_val[k].im};
                end
                else
                begin
                    rv = {near_value(), near_value()};
                end
                write_reg(3'(k), rv);
            end
            case (p)
                2:       write_reg(CFG_TOLERANCE, 64'd0);
                3:       write_reg(CFG_TOLERANCE, 64'h7fff_ffff);
                8:       write_reg(CFG_TOLERANCE, {$urandom, $urandom});
                default: write_reg(CFG_TOLERANCE, 64'($urandom_range(1, 32'h0010_0000)));
            endcase
            // The huge limit comes only with points placed exactly on a root, where
            // f is zero and every point stops after one step.
            case (p)
                3:       write_reg(CFG_LIMIT, 64'd65535);
                4:       write_reg(CFG_LIMIT, 64'd0);
                5:       write_reg(CFG_LIMIT, 64'd1);
                8:       write_reg(CFG_LIMIT, {48'hffff_ffff_ffff, 16'd1});
                default: write_reg(CFG_LIMIT, 64'($urandom_range(1, 4)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == PHASES - 1 && n >= PHASE_ITEMS - QUIET_ITEMS)
                begin
                    quiet = 1'b1;
                end
                case ((p == 3) ? 0 : $urandom_range(0, 9))
                    0:
                    begin
                        rv = {root_val[$urandom_range(0, NROOTS - 1)]};
                        s = '{rv[63:32], rv[31:0]};
                    end
                    1:       s = '{any_value(), any_value()};
                    2:       s = '{32'($urandom), 32'($urandom)};
                    default: s = '{near_value(), near_value()};
                endcase
                send_point(s, 1'b0, '0);
            end
            drain();
        end

        $display("%0d start items sent, %0d result items checked over %0d settings",
                 points_sent, points_checked, PHASES + 2);
        $display("status counts: normal %0d, zero derivative %0d, limit %0d",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", fail_count,
                     pending_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
